// ===== src/olk_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the ordered keyed list.
package olk_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int PAYLOAD_WIDTH_DEF = 64;
	localparam int KEY_W             = 32;
	localparam int REQ_W             = 3;
	localparam int STATUS_W          = 2;

	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LOOKUP    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ_ALL  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		OP_KEEP,
		OP_TAKE_PREV,
		OP_TAKE_NEXT,
		OP_TAKE_NEW,
		OP_TAKE_FRONT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     cmp;  // capture key match this cycle
		logic     occ;  // cell holds a live entry
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_EXEC = 3'b010,
		SQ_DUMP = 3'b100
	} seq_state_t;

endpackage

// ===== src/olk_cell.sv =====
`timescale 1ns / 1ps
// One list slot: holds a key and payload, compares, and passes first-hit along the chain.
module olk_cell #(
	parameter int PAYLOAD_WIDTH = olk_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  olk_pkg::cell_ctrl_t       ctrl,
	input  logic [olk_pkg::KEY_W-1:0] cmp_key,
	input  logic [olk_pkg::KEY_W-1:0] prev_key,
	input  logic [PAYLOAD_WIDTH-1:0]  prev_pay,
	input  logic [olk_pkg::KEY_W-1:0] next_key,
	input  logic [PAYLOAD_WIDTH-1:0]  next_pay,
	input  logic [olk_pkg::KEY_W-1:0] front_key,
	input  logic [PAYLOAD_WIDTH-1:0]  front_pay,
	input  logic [olk_pkg::KEY_W-1:0] new_key,
	input  logic [PAYLOAD_WIDTH-1:0]  new_pay,
	input  logic                      seen_in,
	output logic                      seen_out,
	output logic                      first,
	output logic [olk_pkg::KEY_W-1:0] key_out,
	output logic [PAYLOAD_WIDTH-1:0]  pay_out
);

	logic [olk_pkg::KEY_W-1:0] key_q;
	logic [PAYLOAD_WIDTH-1:0]  pay_q;
	logic                      hit_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			olk_pkg::OP_TAKE_PREV: begin
				key_q <= prev_key;
				pay_q <= prev_pay;
			end
			olk_pkg::OP_TAKE_NEXT: begin
				key_q <= next_key;
				pay_q <= next_pay;
			end
			olk_pkg::OP_TAKE_NEW: begin
				key_q <= new_key;
				pay_q <= new_pay;
			end
			olk_pkg::OP_TAKE_FRONT: begin
				key_q <= front_key;
				pay_q <= front_pay;
			end
			default: begin
				key_q <= key_q;
				pay_q <= pay_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.cmp) begin
			hit_q <= ctrl.occ && (key_q == cmp_key);
		end
	end

	// seen_out is inclusive: this cell and all after the first hit shift on remove
	assign first    = hit_q && !seen_in;
	assign seen_out = hit_q || seen_in;
	assign key_out  = key_q;
	assign pay_out  = pay_q;

endmodule

// ===== src/ordered_keyed_list_top.sv =====
`timescale 1ns / 1ps
// An accepted request is registered; SQ_EXEC forms its result, which is then registered to the ports.
// A new request is held off (busy) until the previous one is done: SQ_EXEC, and SQ_DUMP for a read-out.
// A read-out of N entries emits one entry a cycle by rotating the cell chain.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (arst_n low, async) empties the list; slot contents are left as they were.
module ordered_keyed_list_top #(
	parameter int DEPTH         = olk_pkg::DEPTH_DEF,
	parameter int PAYLOAD_WIDTH = olk_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [olk_pkg::REQ_W-1:0]           req_type,
	input  logic signed [olk_pkg::KEY_W-1:0]    key,
	input  logic [PAYLOAD_WIDTH-1:0]            payload,
	output logic                                strobe,
	output logic [olk_pkg::STATUS_W-1:0]        status,
	output logic signed [olk_pkg::KEY_W-1:0]    key_res,
	output logic [PAYLOAD_WIDTH-1:0]            payload_res,
	output logic                                last
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	olk_pkg::seq_state_t state_q, state_d;
	logic [olk_pkg::REQ_W-1:0]  req_q;
	logic [olk_pkg::KEY_W-1:0]  key_q;
	logic [PAYLOAD_WIDTH-1:0]   pay_q;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [CNT_W-1:0]           idx_q, idx_d;

	logic                       strobe_q, strobe_d;
	logic [olk_pkg::STATUS_W-1:0] status_q, status_d;
	logic [olk_pkg::KEY_W-1:0]  key_res_q, key_res_d;
	logic [PAYLOAD_WIDTH-1:0]   pay_res_q, pay_res_d;
	logic                       last_q, last_d;

	olk_pkg::cell_ctrl_t        ctrl [DEPTH];
	logic [olk_pkg::KEY_W-1:0]  c_key [DEPTH];
	logic [PAYLOAD_WIDTH-1:0]   c_pay [DEPTH];
	logic [DEPTH:0]             seen;
	logic [DEPTH-1:0]           first_vec;
	logic [olk_pkg::KEY_W-1:0]  sel_key;
	logic [PAYLOAD_WIDTH-1:0]   sel_pay;
	logic                       accept;
	logic                       full;
	logic                       any_hit;
	logic                       dump_last;

	assign accept    = start && !busy;
	assign busy      = (state_q != olk_pkg::SQ_IDLE);
	assign full      = (count_q == CNT_FULL);
	assign any_hit   = seen[DEPTH];
	assign dump_last = (idx_q == count_q - CNT_ONE);
	assign seen[0]   = 1'b0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			olk_cell #(
				.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[g]),
				.cmp_key  (key),
				.prev_key ((g == 0) ? key_q : c_key[(g == 0) ? 0 : g - 1]),
				.prev_pay ((g == 0) ? pay_q : c_pay[(g == 0) ? 0 : g - 1]),
				.next_key (c_key[(g == DEPTH - 1) ? g : g + 1]),
				.next_pay (c_pay[(g == DEPTH - 1) ? g : g + 1]),
				.front_key(c_key[0]),
				.front_pay(c_pay[0]),
				.new_key  (key_q),
				.new_pay  (pay_q),
				.seen_in  (seen[g]),
				.seen_out (seen[g+1]),
				.first    (first_vec[g]),
				.key_out  (c_key[g]),
				.pay_out  (c_pay[g])
			);
		end
	endgenerate

	// first_vec is one-hot or zero, so an AND-OR picks the matched entry
	always_comb begin
		sel_key = '0;
		sel_pay = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_key = sel_key | (c_key[i] & {olk_pkg::KEY_W{first_vec[i]}});
			sel_pay = sel_pay | (c_pay[i] & {PAYLOAD_WIDTH{first_vec[i]}});
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].op  = olk_pkg::OP_KEEP;
			ctrl[i].cmp = accept;
			ctrl[i].occ = (CNT_W'(i) < count_q);
		end
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		strobe_d  = 1'b0;
		status_d  = status_q;
		key_res_d = key_res_q;
		pay_res_d = pay_res_q;
		last_d    = last_q;

		case (state_q)
			olk_pkg::SQ_IDLE: begin
				if (accept) begin
					state_d = olk_pkg::SQ_EXEC;
				end
			end
			olk_pkg::SQ_EXEC: begin
				state_d   = olk_pkg::SQ_IDLE;
				key_res_d = '0;
				pay_res_d = '0;
				last_d    = 1'b1;
				case (req_q)
					olk_pkg::REQ_INS_FRONT, olk_pkg::REQ_INS_BACK: begin
						strobe_d = 1'b1;
						if (full) begin
							status_d = olk_pkg::ST_FULL;
						end else begin
							status_d = olk_pkg::ST_OK;
							count_d  = count_q + CNT_ONE;
							for (int i = 0; i < DEPTH; i++) begin
								if (req_q == olk_pkg::REQ_INS_FRONT) begin
									ctrl[i].op = (i == 0) ? olk_pkg::OP_TAKE_NEW
										: olk_pkg::OP_TAKE_PREV;
								end else if (CNT_W'(i) == count_q) begin
									ctrl[i].op = olk_pkg::OP_TAKE_NEW;
								end
							end
						end
					end
					olk_pkg::REQ_REMOVE, olk_pkg::REQ_LOOKUP: begin
						strobe_d = 1'b1;
						if (any_hit) begin
							status_d  = olk_pkg::ST_OK;
							key_res_d = sel_key;
							pay_res_d = sel_pay;
							if (req_q == olk_pkg::REQ_REMOVE) begin
								count_d = count_q - CNT_ONE;
								for (int i = 0; i < DEPTH; i++) begin
									if (seen[i+1]) begin
										ctrl[i].op = olk_pkg::OP_TAKE_NEXT;
									end
								end
							end
						end else begin
							status_d = olk_pkg::ST_NOTFOUND;
						end
					end
					olk_pkg::REQ_READ_ALL: begin
						if (count_q == '0) begin
							strobe_d = 1'b1;
							status_d = olk_pkg::ST_NOTFOUND;
						end else begin
							state_d = olk_pkg::SQ_DUMP;
							idx_d   = '0;
						end
					end
					default: begin
						// unknown request: no result
						strobe_d = 1'b0;
					end
				endcase
			end
			olk_pkg::SQ_DUMP: begin
				// emit the front, rotate it to the back of the live region
				strobe_d  = 1'b1;
				status_d  = olk_pkg::ST_OK;
				key_res_d = c_key[0];
				pay_res_d = c_pay[0];
				last_d    = dump_last;
				idx_d     = idx_q + CNT_ONE;
				for (int i = 0; i < DEPTH; i++) begin
					if (CNT_W'(i) == count_q - CNT_ONE) begin
						ctrl[i].op = olk_pkg::OP_TAKE_FRONT;
					end else if (CNT_W'(i) < count_q) begin
						ctrl[i].op = olk_pkg::OP_TAKE_NEXT;
					end
				end
				if (dump_last) begin
					state_d = olk_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = olk_pkg::SQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= olk_pkg::SQ_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			key_q <= key;
			pay_q <= payload;
		end
		status_q  <= status_d;
		key_res_q <= key_res_d;
		pay_res_q <= pay_res_d;
		last_q    <= last_d;
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign key_res     = key_res_q;
	assign payload_res = pay_res_q;
	assign last        = last_q;

	a_strobe_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without work in the previous cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one first match in the chain");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == olk_pkg::SQ_DUMP) |-> (count_q != '0))
		else $error("read-out running on an empty list");

endmodule
